// ===== hw/rtl/direction_to_equirect_uv_unit_assert.svh =====
// Assertion macros for the equirectangular UV unit.
`ifndef DIRECTION_TO_EQUIRECT_UV_UNIT_ASSERT_SVH
`define DIRECTION_TO_EQUIRECT_UV_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define EQUV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("equv check failed");

// Next-cycle implication, disabled during reset.
`define EQUV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("equv check failed");

`endif

// ===== hw/rtl/equv_pkg.sv =====
// Shared types and constants of the equirectangular UV unit.
package equv_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 34;

    typedef logic signed [ANG_W-1:0] t_ang;

    // atan(2^-i), full turn = 2^32
    function automatic logic [31:0] atan_tab(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/equv_sqrt.sv =====
// Pipelined floor integer square root, one root bit per stage, with side payload.
module equv_sqrt
    import equv_pkg::*;
#(
    parameter int RB    = 24,
    parameter int PAY_W = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RB-1:0]   i_n,
    input  logic [PAY_W-1:0]  i_pay,
    output logic              o_valid,
    output logic [RB-1:0]     o_root,
    output logic [PAY_W-1:0]  o_pay
);

    localparam int NB = 2 * RB;

    logic              r_v    [RB];
    logic [RB-1:0]     r_root [RB];
    logic [NB-1:0]     r_rem  [RB];
    logic [PAY_W-1:0]  r_pay  [RB];

    for (genvar j = 0; j < RB; j++) begin : g_stage
        localparam int K = RB - 1 - j;
        logic             w_v;
        logic [RB-1:0]    w_root;
        logic [NB-1:0]    w_rem;
        logic [PAY_W-1:0] w_pay;
        logic [NB:0]      w_test;
        logic             w_take;

        if (j == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_root = '0;
            assign w_rem  = i_n;
            assign w_pay  = i_pay;
        end else begin : g_next
            assign w_v    = r_v[j-1];
            assign w_root = r_root[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_pay  = r_pay[j-1];
        end

        assign w_test = ((NB+1)'(w_root) << (K + 1)) + ((NB+1)'(1) << (2 * K));
        assign w_take = ({1'b0, w_rem} >= w_test);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pay[j] <= w_pay;
                if (w_take) begin
                    r_rem[j]  <= NB'({1'b0, w_rem} - w_test);
                    r_root[j] <= w_root | (RB'(1) << K);
                end else begin
                    r_rem[j]  <= w_rem;
                    r_root[j] <= w_root;
                end
            end
        end
    end

    assign o_valid = r_v[RB-1];
    assign o_root  = r_root[RB-1];
    assign o_pay   = r_pay[RB-1];

endmodule

// ===== hw/rtl/equv_cordic.sv =====
// Pipelined vectoring CORDIC, one iteration per stage, returns the binary angle.
module equv_cordic
    import equv_pkg::*;
#(
    parameter int DW = 35
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  t_ang                 i_ang,
    output logic                 o_valid,
    output t_ang                 o_ang
);

    logic                 r_v   [CORDIC_STEPS];
    logic signed [DW-1:0] r_x   [CORDIC_STEPS];
    logic signed [DW-1:0] r_y   [CORDIC_STEPS];
    t_ang                 r_ang [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic                 w_v;
        logic signed [DW-1:0] w_x, w_y, w_dx, w_dy;
        t_ang                 w_ang, w_tab;

        if (i == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_x   = i_x;
            assign w_y   = i_y;
            assign w_ang = i_ang;
        end else begin : g_next
            assign w_v   = r_v[i-1];
            assign w_x   = r_x[i-1];
            assign w_y   = r_y[i-1];
            assign w_ang = r_ang[i-1];
        end

        assign w_dx  = w_y >>> i;
        assign w_dy  = w_x >>> i;
        assign w_tab = t_ang'({2'b00, atan_tab(i)});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y > 0) begin
                    r_x[i]   <= w_x + w_dx;
                    r_y[i]   <= w_y - w_dy;
                    r_ang[i] <= w_ang + w_tab;
                end else if (w_y < 0) begin
                    r_x[i]   <= w_x - w_dx;
                    r_y[i]   <= w_y + w_dy;
                    r_ang[i] <= w_ang - w_tab;
                end else begin
                    r_x[i]   <= w_x;
                    r_y[i]   <= w_y;
                    r_ang[i] <= w_ang;
                end
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];
    assign o_ang   = r_ang[CORDIC_STEPS-1];

endmodule

// ===== hw/rtl/direction_to_equirect_uv_unit.sv =====
// Equirectangular UV mapping of a 3D position: top level.
// Takes one (x, y, z) request per cycle and returns (u, v) in unsigned Q0.UV_FRAC_BITS.
// The pipeline has input, square and scaling stages, one stage per root bit of the
// square root, then 30 CORDIC stages (longitude and latitude in parallel), then
// rounding and the output register. Throughput is one request per cycle; a two-entry
// output buffer lets input flow on while a result waits, and the whole pipe holds only
// when that buffer is full.
`include "direction_to_equirect_uv_unit_assert.svh"
module direction_to_equirect_uv_unit
    import equv_pkg::*;
#(
    parameter int COORD_WIDTH  = 16,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // pos_x, pos_y, pos_z, zero pad
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tex_u, tex_v
    output logic [31:0]                            o_m_tdata
);

    localparam int W     = COORD_WIDTH;
    localparam int GUARD = (W <= 24) ? 8 : (32 - W);
    localparam int PRE1  = (W < 29) ? (29 - W) : 0;
    localparam int PRE2  = (W + GUARD < 29) ? (29 - W - GUARD) : 0;
    localparam int RB    = W + GUARD;
    localparam int NB    = 2 * RB;
    localparam int CW1   = W + PRE1;
    localparam int CW2   = RB + PRE2;
    localparam int CW    = ((CW1 > CW2) ? CW1 : CW2) + 3;
    localparam int PAY_W = 3 * W + 4;
    localparam int SH    = 32 - UV_FRAC_BITS;

    localparam logic [1:0] ST_ZERO = 2'd0;
    localparam logic [1:0] ST_POS  = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    logic w_en;

    // output register and skid entry valid bits
    logic r_out_v, r_skid_v;

    // stage A: capture
    logic                r_a_v;
    logic signed [W-1:0] r_a_x, r_a_y, r_a_z;

    // stage B: squares, half-plane fold
    logic                r_b_v;
    logic [2*W-1:0]      r_b_sx, r_b_sz;
    logic signed [W:0]   r_b_cx, r_b_cz;
    logic signed [W-1:0] r_b_y;
    logic [1:0]          r_b_st;

    // stage C: scaled radius squared
    logic                r_c_v;
    logic [NB-1:0]       r_c_n;
    logic [PAY_W-1:0]    r_c_pay;

    logic signed [W:0]   w_ax, w_az, w_nx, w_nz;

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_s_tvalid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    assign w_nx = -(W+1)'(r_a_x);
    assign w_nz = -(W+1)'(r_a_z);
    assign w_ax = r_a_x[W-1] ? w_nx : (W+1)'(r_a_x);
    assign w_az = r_a_z[W-1] ? w_nz : (W+1)'(r_a_z);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_x  <= i_s_tdata[W-1:0];
            r_a_y  <= i_s_tdata[2*W-1:W];
            r_a_z  <= i_s_tdata[3*W-1:2*W];

            r_b_sx <= w_ax[W-1:0] * w_ax[W-1:0];
            r_b_sz <= w_az[W-1:0] * w_az[W-1:0];
            r_b_y  <= r_a_y;
            if (r_a_x[W-1]) begin
                r_b_cx <= w_nx;
                r_b_cz <= w_nz;
                r_b_st <= r_a_z[W-1] ? ST_NEG : ST_POS;
            end else begin
                r_b_cx <= (W+1)'(r_a_x);
                r_b_cz <= (W+1)'(r_a_z);
                r_b_st <= ST_ZERO;
            end

            r_c_n   <= NB'(r_b_sx + r_b_sz) << (2 * GUARD);
            r_c_pay <= {r_b_cx, r_b_cz, r_b_y, r_b_st};
        end
    end

    logic              w_q_v;
    logic [RB-1:0]     w_q_root;
    logic [PAY_W-1:0]  w_q_pay;

    equv_sqrt #(
        .RB    (RB),
        .PAY_W (PAY_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_n     (r_c_n),
        .i_pay   (r_c_pay),
        .o_valid (w_q_v),
        .o_root  (w_q_root),
        .o_pay   (w_q_pay)
    );

    logic signed [W:0]    w_p_cx, w_p_cz;
    logic signed [W-1:0]  w_p_y;
    logic [1:0]           w_p_st;
    logic signed [CW-1:0] w_x1, w_y1, w_x2, w_y2;
    t_ang                 w_start;

    assign {w_p_cx, w_p_cz, w_p_y, w_p_st} = w_q_pay;

    assign w_x1 = CW'(w_p_cx) <<< PRE1;
    assign w_y1 = CW'(w_p_cz) <<< PRE1;
    assign w_x2 = CW'(w_q_root) <<< PRE2;
    assign w_y2 = CW'(w_p_y) <<< (GUARD + PRE2);

    always_comb begin
        case (w_p_st)
            ST_POS:  w_start = t_ang'(34'sd2147483648);
            ST_NEG:  w_start = -t_ang'(34'sd2147483648);
            default: w_start = '0;
        endcase
    end

    logic w_c1_v, w_c2_v;
    t_ang w_au, w_av;

    equv_cordic #(.DW(CW)) u_cordic_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_q_v),
        .i_x     (w_x1),
        .i_y     (w_y1),
        .i_ang   (w_start),
        .o_valid (w_c1_v),
        .o_ang   (w_au)
    );

    equv_cordic #(.DW(CW)) u_cordic_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_q_v),
        .i_x     (w_x2),
        .i_y     (w_y2),
        .i_ang   ('0),
        .o_valid (w_c2_v),
        .o_ang   (w_av)
    );

    function automatic logic [15:0] to_uv(input logic signed [35:0] num);
        logic [32:0] cl;
        logic [33:0] q;
        if (num < 0) begin
            cl = '0;
        end else if (num > 36'sh100000000) begin
            cl = 33'h100000000;
        end else begin
            cl = num[32:0];
        end
        q = (34'(cl) + (34'd1 << (SH - 1))) >> SH;
        if (q > ((34'd1 << UV_FRAC_BITS) - 34'd1)) begin
            q = (34'd1 << UV_FRAC_BITS) - 34'd1;
        end
        return q[15:0];
    endfunction

    logic signed [35:0] w_num_u, w_num_v;
    logic               r_f_v;
    logic [15:0]        r_f_u, r_f_vv;

    assign w_num_u = 36'(w_au) + 36'sh80000000;
    assign w_num_v = 36'sh80000000 - (36'(w_av) <<< 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_u  <= to_uv(w_num_u);
            r_f_vv <= to_uv(w_num_v);
        end
    end

    // output register plus skid entry
    logic [31:0] r_out_d, r_skid_d;
    logic        w_pop;
    logic        w_skid_fill;

    assign w_pop       = r_out_v && i_m_tready;
    assign w_skid_fill = r_f_v && r_out_v && !i_m_tready && !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_f_v) begin
            if (!r_out_v || w_pop) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_out_d <= r_skid_d;
            end
        end else if (r_f_v) begin
            if (!r_out_v || w_pop) begin
                r_out_d <= {r_f_vv, r_f_u};
            end else begin
                r_skid_d <= {r_f_vv, r_f_u};
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_d;

    `EQUV_ASSERT_NOW(a_cordic_lockstep, i_clk, i_rst_n, 1'b1, w_c1_v == w_c2_v)
    `EQUV_ASSERT_NOW(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `EQUV_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, w_skid_fill, r_skid_v && r_out_v)

endmodule

// ===== tb/equv_checker.sv =====
// Checker for the equirectangular UV unit: predicts each request and compares results.
module equv_checker
    import equv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int GUARD_BITS = 8;
    localparam int PRE_LON    = 13;
    localparam int PRE_LAT    = 5;

    logic [31:0] uv_queue [$];

    function automatic longint vector_angle(longint vx, longint vy, longint start);
        longint ang;
        longint dx;
        longint dy;
        ang = start;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx = vx + dx;
                vy = vy - dy;
                ang = ang + longint'(atan_tab(i));
            end else if (vy < 0) begin
                vx = vx - dx;
                vy = vy + dy;
                ang = ang - longint'(atan_tab(i));
            end
        end
        return ang;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [15:0] angle_to_coord(longint num);
        longint q;
        if (num < 0) num = 0;
        if (num > (64'sd1 <<< 32)) num = 64'sd1 <<< 32;
        q = (num + (64'sd1 <<< 15)) >>> 16;
        if (q > 65535) q = 65535;
        return q[15:0];
    endfunction

    function automatic logic [31:0] predict_uv(logic [47:0] pos);
        longint px;
        longint py;
        longint pz;
        longint cx;
        longint cz;
        longint start;
        longint rad;
        longint ang_u;
        longint ang_v;
        px = longint'($signed(pos[15:0]));
        py = longint'($signed(pos[31:16]));
        pz = longint'($signed(pos[47:32]));
        cx = px;
        cz = pz;
        start = 0;
        if (px < 0) begin
            cx = -px;
            cz = -pz;
            start = (pz >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
        end
        ang_u = vector_angle(cx <<< PRE_LON, cz <<< PRE_LON, start);
        rad = floor_sqrt(longint'(unsigned'(px * px + pz * pz)) << (2 * GUARD_BITS));
        ang_v = vector_angle(rad <<< PRE_LAT, (py <<< GUARD_BITS) <<< PRE_LAT, 0);
        return {angle_to_coord((64'sd1 <<< 31) - 2 * ang_v),
                angle_to_coord(ang_u + (64'sd1 <<< 31))};
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] want;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) uv_queue.push_back(predict_uv(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (uv_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_m_tdata);
                    errs = errs + 1;
                end else begin
                    want = uv_queue.pop_front();
                    if (want[15:0] !== i_m_tdata[15:0]) begin
                        $display("%0t: tex_u expected %h actual %h", $time, want[15:0],
                                 i_m_tdata[15:0]);
                        errs = errs + 1;
                    end
                    if (want[31:16] !== i_m_tdata[31:16]) begin
                        $display("%0t: tex_v expected %h actual %h", $time, want[31:16],
                                 i_m_tdata[31:16]);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= uv_queue.size();
        end
    end
endmodule

// ===== tb/tb_direction_to_equirect_uv_unit.sv =====
// Testbench top for the equirectangular UV unit: stimulus, back-pressure and verdict.
module tb_direction_to_equirect_uv_unit;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          cycles;
    int          sent;

    direction_to_equirect_uv_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    equv_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (cycles > 300000) begin
            $display("tb_direction_to_equirect_uv_unit failed");
            $finish;
        end
    end

    task automatic send_pos(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(16) - 8);
            1:       return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] dir_vals [7] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                                      16'h0001, 16'hFFFF};
        cycles      = 0;
        sent        = 0;
        tx_idle_pct = 23;
        rx_idle_pct = 80;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // zero vector, axes both ways, poles, extremes
        send_pos(16'h0000, 16'h0000, 16'h0000);
        send_pos(16'hC000, 16'h0000, 16'h0000);
        send_pos(16'h8000, 16'h1234, 16'h0000);
        send_pos(16'h0000, 16'h8000, 16'h0000);
        send_pos(16'h0000, 16'h7FFF, 16'h0000);
        for (int k = 0; k < 7; k++) send_pos(dir_vals[k], dir_vals[(k + 3) % 7],
                                            dir_vals[(k + 5) % 7]);
        send_pos(16'h4000, 16'h0000, 16'h0000);
        send_pos(16'h0000, 16'h0000, 16'h4000);
        send_pos(16'h0000, 16'h0000, 16'hC000);
        send_pos(16'h8000, 16'h8000, 16'h8000);
        send_pos(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pos(16'h8000, 16'h7FFF, 16'hFFFF);
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 80 : 0;
            rx_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 23 : 0;
            repeat (160) send_pos(rand_coord(), rand_coord(), rand_coord());
            repeat (10) send_pos(16'($urandom), 16'($urandom), 16'($urandom));
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("Sent %0d positions: zero vector, axes, poles, extremes and random mixes,",
                 sent);
        $display("under sender and receiver stalls in both ratios and at full rate.");
        if (fail_count == 0) begin
            $display("tb_direction_to_equirect_uv_unit passed");
        end else begin
            $display("tb_direction_to_equirect_uv_unit failed");
        end
        $finish;
    end
endmodule
